// ===== rtl/core/fpr_pkg.sv =====
package fpr_pkg;

   localparam int unsigned FRAME_LEN = 8;
   // bytes kept between requests; the eighth comes straight from the input register
   localparam int unsigned HELD_LEN  = FRAME_LEN - 1;
   localparam int unsigned FILL_W    = $clog2(FRAME_LEN);

   localparam logic [7:0] GROUP_TYPE        = 8'd17;
   localparam logic [7:0] MAX_DIMMER_OFFSET = 8'd3;

   localparam logic [7:0] START_BYTE_RESET     = 8'd2;
   localparam logic [7:0] END_BYTE_RESET       = 8'd3;
   localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd1;

   typedef logic [7:0] byte_type;

   // position 0 is the oldest byte
   typedef byte_type [FRAME_LEN-1:0] frame_type;

   typedef enum logic [1:0] {
      CSR_START_BYTE,
      CSR_END_BYTE,
      CSR_DEVICE_ADDRESS,
      CSR_DIMMER_MODE
   } csr_index_type;

   typedef struct packed {
      byte_type start_byte;
      byte_type end_byte;
      byte_type device_address;
      logic     dimmer_mode;
   } csr_type;

   typedef struct packed {
      logic     frame_ok;
      byte_type destination;
      byte_type source;
      byte_type message_type;
      byte_type info_first;
      byte_type info_second;
      logic     for_this_device;
   } frame_info_type;

endpackage

// ===== rtl/core/fpr_frame_check.sv =====
module fpr_frame_check
   import fpr_pkg::*;
(
   input  frame_type      frame,
   input  csr_type        csr,
   output frame_info_type info
);

   byte_type   sum;
   logic [8:0] diff;
   logic       near;

   always_comb begin
      sum = csr.start_byte + frame[1] + frame[2] + frame[3] + frame[4] + frame[5];

      // no wrap: destination below the address gives a borrow
      diff = {1'b0, frame[1]} - {1'b0, csr.device_address};
      near = !diff[8] && (diff[7:0] != 8'd0) && (diff[7:0] <= MAX_DIMMER_OFFSET);

      info.frame_ok        = (frame[0] == csr.start_byte) &&
                             (frame[FRAME_LEN-1] == csr.end_byte) &&
                             (sum == frame[6]);
      info.destination     = frame[1];
      info.source          = frame[2];
      info.message_type    = frame[3];
      info.info_first      = frame[4];
      info.info_second     = frame[5];
      info.for_this_device = (frame[1] == csr.device_address) ||
                             (csr.dimmer_mode && near);
   end

endmodule

// ===== rtl/core/framed_packet_receiver.sv =====
// Framed packet receiver.
// Request channel (req_valid / req_stall / req_rx_byte): one received serial
// byte per request. Result channel (rsp_valid / rsp_stall / rsp_*): one
// result per valid frame (start, destination, source, type, info 1, info 2,
// checksum, end), with the address match and new group command flags.
// Configuration: csr_write_enable / csr_index / csr_write_data, write only,
// to be used while no request is in flight.
// Throughput: one byte per cycle while req_stall is low. A byte passes
// through an input register; the frame check (byte compares and a six-byte
// add) sits between that register and the result register, which captures
// the result for a frame once its end byte leaves the input register.
// A full window that fails the check drops its oldest byte and emits nothing.
// When the receiver stalls, bytes that complete no frame keep flowing; a byte
// that completes a valid frame waits in the input register until the result
// register is free, and req_stall is raised for as long as it waits.
// Reset (synchronous, active high) empties the window, forgets the last group
// pair and restores the configuration defaults.
module framed_packet_receiver
   import fpr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_destination,
   output logic [7:0] rsp_source,
   output logic [7:0] rsp_message_type,
   output logic [7:0] rsp_info_first,
   output logic [7:0] rsp_info_second,
   output logic       rsp_for_this_device,
   output logic       rsp_new_group_command,

   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data
);

   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HELD_LEN);

   csr_type              csr_ff;

   logic                 in_valid_ff, in_valid_in;
   byte_type             in_byte_ff;

   byte_type             win_ff [HELD_LEN];
   byte_type             win_in [HELD_LEN];
   logic [FILL_W-1:0]    fill_ff, fill_in;

   logic                 seen_ff, seen_in;
   byte_type             last_src_ff, last_src_in;
   byte_type             last_dst_ff, last_dst_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   frame_info_type       rsp_info_ff;
   logic                 rsp_newgrp_ff;

   frame_type            frame;
   frame_info_type       info;
   logic                 req_take;
   logic                 hit;
   logic                 out_free;
   logic                 advance;
   logic                 newgrp;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.start_byte     <= START_BYTE_RESET;
         csr_ff.end_byte       <= END_BYTE_RESET;
         csr_ff.device_address <= DEVICE_ADDRESS_RESET;
         csr_ff.dimmer_mode    <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_BYTE:     csr_ff.start_byte     <= csr_write_data;
            CSR_END_BYTE:       csr_ff.end_byte       <= csr_write_data;
            CSR_DEVICE_ADDRESS: csr_ff.device_address <= csr_write_data;
            CSR_DIMMER_MODE:    csr_ff.dimmer_mode    <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < HELD_LEN; i++) begin
         frame[i] = win_ff[i];
      end
      frame[FRAME_LEN-1] = in_byte_ff;
   end

   fpr_frame_check u_check (
      .frame (frame),
      .csr   (csr_ff),
      .info  (info)
   );

   always_comb begin
      hit       = (fill_ff == FILL_FULL) && info.frame_ok;
      out_free  = !rsp_valid_ff || !rsp_stall;
      advance   = in_valid_ff && (!hit || out_free);
      req_stall = in_valid_ff && !advance;
      req_take  = req_valid && !req_stall;

      in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

      win_in  = win_ff;
      fill_in = fill_ff;
      if (advance) begin
         if (fill_ff != FILL_FULL) begin
            win_in[fill_ff] = in_byte_ff;
            fill_in         = fill_ff + 1'b1;
         end else if (info.frame_ok) begin
            fill_in = '0;
         end else begin
            // bad window: slide by one to resynchronize
            for (int i = 0; i < HELD_LEN; i++) begin
               win_in[i] = frame[i+1];
            end
         end
      end

      newgrp      = (info.message_type == GROUP_TYPE) &&
                    (!seen_ff || info.source != last_src_ff ||
                     info.destination != last_dst_ff);
      seen_in     = seen_ff;
      last_src_in = last_src_ff;
      last_dst_in = last_dst_ff;
      if (advance && hit && newgrp) begin
         seen_in     = 1'b1;
         last_src_in = info.source;
         last_dst_in = info.destination;
      end

      if (advance && hit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         fill_ff      <= '0;
         seen_ff      <= 1'b0;
         last_src_ff  <= '0;
         last_dst_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         fill_ff      <= fill_in;
         seen_ff      <= seen_in;
         last_src_ff  <= last_src_in;
         last_dst_ff  <= last_dst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
      win_ff <= win_in;
      if (advance && hit) begin
         rsp_info_ff   <= info;
         rsp_newgrp_ff <= newgrp;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_destination       = rsp_info_ff.destination;
   assign rsp_source            = rsp_info_ff.source;
   assign rsp_message_type      = rsp_info_ff.message_type;
   assign rsp_info_first        = rsp_info_ff.info_first;
   assign rsp_info_second       = rsp_info_ff.info_second;
   assign rsp_for_this_device   = rsp_info_ff.for_this_device;
   assign rsp_new_group_command = rsp_newgrp_ff;

endmodule

// ===== test/tb_framed_packet_receiver.sv =====
module tb_framed_packet_receiver;
   import fpr_pkg::*;

   localparam int PHASE_BYTES   = 175;
   localparam int PHASE_COUNT   = 8;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT   = 4000;

   typedef enum int {
      FLAW_NONE,
      FLAW_CHECKSUM,
      FLAW_END,
      FLAW_START,
      FLAW_TRUNCATED
   } flaw_kind_type;

   typedef struct {
      byte_type destination;
      byte_type source;
      byte_type message_type;
      byte_type info_first;
      byte_type info_second;
      logic     for_this_device;
      logic     new_group_command;
   } frame_fields_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_rx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_destination;
   logic [7:0] rsp_source;
   logic [7:0] rsp_message_type;
   logic [7:0] rsp_info_first;
   logic [7:0] rsp_info_second;
   logic       rsp_for_this_device;
   logic       rsp_new_group_command;
   logic       csr_write_enable;
   logic [1:0] csr_index;
   logic [7:0] csr_write_data;

   framed_packet_receiver dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_rx_byte           (req_rx_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_destination       (rsp_destination),
      .rsp_source            (rsp_source),
      .rsp_message_type      (rsp_message_type),
      .rsp_info_first        (rsp_info_first),
      .rsp_info_second       (rsp_info_second),
      .rsp_for_this_device   (rsp_for_this_device),
      .rsp_new_group_command (rsp_new_group_command),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   // receiver model state
   byte_type    cfg_start;
   byte_type    cfg_end;
   byte_type    cfg_dev;
   logic        cfg_dimmer;
   byte_type    window[FRAME_LEN];
   int unsigned fill;
   byte_type    grp_src;
   byte_type    grp_dst;
   logic        grp_seen;

   byte_type         rx_queue[$];
   frame_fields_type decoded_frames[$];

   int errors;
   int quiet_cycles;
   int sender_idle_pct;
   int rsp_stall_pct;

   function automatic void reset_model();
      cfg_start  = START_BYTE_RESET;
      cfg_end    = END_BYTE_RESET;
      cfg_dev    = DEVICE_ADDRESS_RESET;
      cfg_dimmer = 1'b0;
      for (int i = 0; i < FRAME_LEN; i++) window[i] = 8'd0;
      fill     = 0;
      grp_src  = 8'd0;
      grp_dst  = 8'd0;
      grp_seen = 1'b0;
   endfunction

   function automatic void apply_reg(csr_index_type idx, byte_type val);
      case (idx)
         CSR_START_BYTE:     cfg_start  = val;
         CSR_END_BYTE:       cfg_end    = val;
         CSR_DEVICE_ADDRESS: cfg_dev    = val;
         CSR_DIMMER_MODE:    cfg_dimmer = val[0];
         default: ;
      endcase
   endfunction

   // shift one byte into the window; push a decoded frame when it completes one
   function automatic void decode_byte(byte_type b);
      int unsigned      sum;
      logic             ok;
      frame_fields_type r;
      window[fill] = b;
      fill++;
      if (fill < FRAME_LEN) return;
      sum = cfg_start;
      for (int i = 1; i <= 5; i++) sum += window[i];
      ok = (window[0] == cfg_start) && (window[7] == cfg_end) && ((sum & 255) == window[6]);
      if (!ok) begin
         // resync: drop the oldest byte
         for (int i = 0; i < FRAME_LEN - 1; i++) window[i] = window[i+1];
         fill = FRAME_LEN - 1;
         return;
      end
      r.destination  = window[1];
      r.source       = window[2];
      r.message_type = window[3];
      r.info_first   = window[4];
      r.info_second  = window[5];
      // dimmer offsets do not wrap past 255
      r.for_this_device = (window[1] == cfg_dev) ||
                          (cfg_dimmer && int'(window[1]) >= int'(cfg_dev) + 1 &&
                           int'(window[1]) <= int'(cfg_dev) + 3);
      r.new_group_command = 1'b0;
      if (window[3] == GROUP_TYPE &&
          (!grp_seen || window[2] != grp_src || window[1] != grp_dst)) begin
         r.new_group_command = 1'b1;
         grp_seen = 1'b1;
         grp_src  = window[2];
         grp_dst  = window[1];
      end
      decoded_frames.push_back(r);
      fill = 0;
   endfunction

   function automatic void add_frame(byte_type dst, byte_type src, byte_type typ,
                                     byte_type i1, byte_type i2, flaw_kind_type flaw);
      byte_type bytes[FRAME_LEN];
      int       keep;
      bytes[0] = cfg_start;
      bytes[1] = dst;
      bytes[2] = src;
      bytes[3] = typ;
      bytes[4] = i1;
      bytes[5] = i2;
      bytes[6] = byte_type'(cfg_start + dst + src + typ + i1 + i2);
      bytes[7] = cfg_end;
      keep = FRAME_LEN;
      case (flaw)
         FLAW_CHECKSUM:  bytes[6] = bytes[6] ^ byte_type'($urandom_range(1, 255));
         FLAW_END:       bytes[7] = bytes[7] ^ byte_type'($urandom_range(1, 255));
         FLAW_START:     bytes[0] = bytes[0] ^ byte_type'($urandom_range(1, 255));
         FLAW_TRUNCATED: keep = $urandom_range(1, FRAME_LEN - 1);
         default: ;
      endcase
      for (int i = 0; i < keep; i++) rx_queue.push_back(bytes[i]);
   endfunction

   function automatic byte_type pick_dst();
      int r;
      r = $urandom_range(9);
      if (r < 5) return byte_type'(cfg_dev + $urandom_range(4));
      if (r == 5) return 8'd0;
      if (r == 6) return 8'hFF;
      return byte_type'($urandom_range(255));
   endfunction

   function automatic void fill_random(int n);
      int       target;
      int       r;
      int       cnt;
      byte_type typ;
      byte_type src;
      target = rx_queue.size() + n;
      while (rx_queue.size() < target) begin
         r = $urandom_range(99);
         if (r < 84) begin
            // group commands from a few sources so pairs repeat
            if ($urandom_range(3) < 2) begin
               typ = GROUP_TYPE;
               src = byte_type'($urandom_range(2));
            end else begin
               typ = byte_type'($urandom_range(255));
               src = byte_type'($urandom_range(255));
            end
            add_frame(pick_dst(), src, typ, byte_type'($urandom_range(255)),
                      byte_type'($urandom_range(255)),
                      r < 72 ? FLAW_NONE : flaw_kind_type'($urandom_range(1, 4)));
         end else if (r < 92) begin
            cnt = $urandom_range(1, 5);
            repeat (cnt) rx_queue.push_back(byte_type'($urandom_range(255)));
         end else begin
            // false starts
            cnt = $urandom_range(1, 3);
            repeat (cnt) rx_queue.push_back(cfg_start);
         end
      end
   endfunction

   task automatic write_reg(csr_index_type idx, byte_type val);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      apply_reg(idx, val);
   endtask

   task automatic program_regs(byte_type s, byte_type e, byte_type dev, byte_type dim);
      write_reg(CSR_START_BYTE, s);
      write_reg(CSR_END_BYTE, e);
      write_reg(CSR_DEVICE_ADDRESS, dev);
      write_reg(CSR_DIMMER_MODE, dim);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic wait_idle();
      while (rx_queue.size() != 0 || req_valid) @(posedge clock);
      while (decoded_frames.size() != 0) @(posedge clock);
      // bytes that complete no frame may still be in the pipeline
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (rx_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_valid   <= 1'b1;
            req_rx_byte <= rx_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < rsp_stall_pct);
   end

   // monitor: feed accepted requests to the model, compare results
   always @(posedge clock) begin
      frame_fields_type want;
      if (!reset) begin
         if (req_valid && !req_stall) decode_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall) begin
            if (decoded_frames.size() == 0) begin
               $display("%0t unexpected frame: expected none actual dst %0d src %0d type %0d",
                        $time, rsp_destination, rsp_source, rsp_message_type);
               errors++;
            end else begin
               want = decoded_frames.pop_front();
               check_field("destination", want.destination, rsp_destination);
               check_field("source", want.source, rsp_source);
               check_field("message_type", want.message_type, rsp_message_type);
               check_field("info_first", want.info_first, rsp_info_first);
               check_field("info_second", want.info_second, rsp_info_second);
               check_field("for_this_device", 8'(want.for_this_device),
                           8'(rsp_for_this_device));
               check_field("new_group_command", 8'(want.new_group_command),
                           8'(rsp_new_group_command));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_framed_packet_receiver: errors");
         $finish;
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_rx_byte      = 8'd0;
      rsp_stall        = 1'b0;
      csr_write_enable = 1'b0;
      csr_index        = CSR_START_BYTE;
      csr_write_data   = 8'd0;
      sender_idle_pct  = 0;
      rsp_stall_pct    = 0;
      errors           = 0;
      quiet_cycles     = 0;
      reset_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset configuration; first group command, repeated pair, all-ones fields
      add_frame(8'd1, 8'd0, GROUP_TYPE, 8'd0, 8'd0, FLAW_NONE);
      add_frame(8'd1, 8'd0, GROUP_TYPE, 8'hFF, 8'hFF, FLAW_NONE);
      add_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, FLAW_NONE);
      fill_random(PHASE_BYTES - 3 * FRAME_LEN);
      wait_idle();

      for (int p = 1; p < PHASE_COUNT; p++) begin
         case (p % 4)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 59; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 59; end
            default: begin sender_idle_pct = 21; rsp_stall_pct = 21; end
         endcase
         // upper data bits of the dimmer write must be dropped
         case (p)
            1: program_regs(8'h00, 8'hFF, 8'h00, 8'h00);
            2: program_regs(8'hFF, 8'h00, 8'hFF, 8'hFF);
            3: program_regs(8'h7E, 8'h7E, 8'hFE, 8'h01);
            4: program_regs(byte_type'($urandom_range(255)), byte_type'($urandom_range(255)),
                            byte_type'($urandom_range(1, 255)), 8'hFE);
            5: program_regs(byte_type'($urandom_range(255)), byte_type'($urandom_range(255)),
                            byte_type'($urandom_range(1, 255)), 8'h81);
            default: program_regs(byte_type'($urandom_range(255)),
                                  byte_type'($urandom_range(255)),
                                  byte_type'($urandom_range(255)),
                                  byte_type'($urandom_range(255)));
         endcase
         fill_random(PHASE_BYTES);
         wait_idle();
      end

      if (errors == 0)
         $display("tb_framed_packet_receiver: clean");
      else
         $display("tb_framed_packet_receiver: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/fpr_pkg.sv
rtl/core/fpr_frame_check.sv
rtl/core/framed_packet_receiver.sv
test/tb_framed_packet_receiver.sv
